// ===== hw/rtl/double_ended_queue_assert.svh =====
// assertion macros shared by the double-ended queue rtl
`ifndef DOUBLE_ENDED_QUEUE_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DEQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("double_ended_queue: same-cycle check failed");

// next-cycle implication, disabled during reset
`define DEQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("double_ended_queue: next-cycle check failed");

`endif

// ===== hw/rtl/deq_pkg.sv =====
// types and codes of the double-ended queue
`timescale 1ns / 1ps

package deq_pkg;

  localparam int WORD_W      = 32;
  localparam int POS_W       = 7;
  localparam int KIND_W      = 3;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 40;

  typedef logic [KIND_W-1:0]   kind_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam kind_t KIND_BUILD  = 3'd0;
  localparam kind_t KIND_PUSH_F = 3'd1;
  localparam kind_t KIND_PUSH_B = 3'd2;
  localparam kind_t KIND_POP_F  = 3'd3;
  localparam kind_t KIND_POP_B  = 3'd4;
  localparam kind_t KIND_DUMP   = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_EMPTY = 2'd1;
  localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== hw/rtl/deq_ram.sv =====
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/double_ended_queue.sv =====
// top level of the double-ended queue: ring pointers, control and output register
//
//  channel | direction | tdata                           | tuser     | tlast
//  in_     | slave     | value[31:0], start_new[32]      | kind[2:0] | -
//  out_    | master    | value_res[31:0], position[38:32]| status    | last
//
// end operations: accept with ram access, then output register load in S_RESP once the output is free
// a dump of n words makes one ram read per word on the single read port
// items with an unused kind are accepted and give no result
// rst_n clears pointers, count and control; the word ram is not cleared
// a stalled output holds the result; the next item is accepted while it waits
`timescale 1ns / 1ps
`include "double_ended_queue_assert.svh"

module double_ended_queue #(
  parameter int DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]    in_tdata,   // value, start_new
  input  logic [deq_pkg::KIND_W-1:0]        in_tuser,   // kind
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata,  // value_res, position, zero pad
  output logic [deq_pkg::STATUS_W-1:0]      out_tuser,  // status
  output logic                              out_tlast
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_X  = (AW + 1)'(DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RESP = 2'd1;
  localparam logic [1:0] S_DOUT = 2'd2;

  function automatic logic [AW-1:0] ring_idx(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= DEPTH_X) begin
      sum = sum - DEPTH_X;
    end
    return sum[AW-1:0];
  endfunction

  logic [1:0]                    state_r, state_nxt;
  logic [AW-1:0]                 front_r, front_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  deq_pkg::status_t              res_status_r, res_status_nxt;
  logic                          res_ram_r, res_ram_nxt;
  logic                          out_valid_r, out_valid_nxt;
  deq_pkg::status_t              out_status_r, out_status_nxt;
  logic [deq_pkg::WORD_W-1:0]    out_value_r, out_value_nxt;
  logic [deq_pkg::POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic                          out_last_r, out_last_nxt;

  deq_pkg::kind_t                in_kind;
  logic [deq_pkg::WORD_W-1:0]    in_value;
  logic                          in_fresh;
  logic                          in_acc;
  logic                          out_free;
  logic [AW-1:0]                 front_inc, front_dec;
  logic [CW-1:0]                 cnt_m1;
  logic [AW-1:0]                 eff_front;
  logic [CW-1:0]                 eff_count;
  logic [CW-1:0]                 dump_pos;
  logic                          dump_last;

  logic                          ram_we, ram_re;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  logic [deq_pkg::WORD_W-1:0]    ram_rdata;

  assign in_kind   = in_tuser;
  assign in_value  = in_tdata[deq_pkg::WORD_W-1:0];
  assign in_fresh  = in_tdata[deq_pkg::WORD_W];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign front_inc = (front_r == LAST_IDX) ? '0 : front_r + AW'(1);
  assign front_dec = (front_r == '0) ? LAST_IDX : front_r - AW'(1);
  assign cnt_m1    = count_r - CW'(1);
  assign eff_front = in_fresh ? '0 : front_r;
  assign eff_count = in_fresh ? '0 : count_r;
  assign dump_pos  = CW'(idx_r) + CW'(1);
  assign dump_last = (dump_pos == count_r);

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    res_status_nxt = res_status_r;
    res_ram_nxt    = res_ram_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_pos_nxt    = out_pos_r;
    out_last_nxt   = out_last_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_ram_nxt = 1'b0;
          case (in_kind)
            deq_pkg::KIND_BUILD: begin
              state_nxt = S_RESP;
              front_nxt = eff_front;
              count_nxt = eff_count;
              if (eff_count == CNT_FULL) begin
                res_status_nxt = deq_pkg::ST_FULL;
              end else begin
                res_status_nxt = deq_pkg::ST_OK;
                ram_we         = 1'b1;
                ram_waddr      = ring_idx(eff_front, eff_count[AW-1:0]);
                count_nxt      = eff_count + CW'(1);
              end
            end
            deq_pkg::KIND_PUSH_F, deq_pkg::KIND_PUSH_B: begin
              state_nxt = S_RESP;
              if (count_r == '0) begin
                res_status_nxt = deq_pkg::ST_EMPTY;
              end else if (count_r == CNT_FULL) begin
                res_status_nxt = deq_pkg::ST_FULL;
              end else begin
                res_status_nxt = deq_pkg::ST_OK;
                ram_we         = 1'b1;
                count_nxt      = count_r + CW'(1);
                if (in_kind == deq_pkg::KIND_PUSH_F) begin
                  front_nxt = front_dec;
                  ram_waddr = front_dec;
                end else begin
                  ram_waddr = ring_idx(front_r, count_r[AW-1:0]);
                end
              end
            end
            deq_pkg::KIND_POP_F, deq_pkg::KIND_POP_B: begin
              state_nxt = S_RESP;
              if (count_r == '0) begin
                res_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                res_status_nxt = deq_pkg::ST_OK;
                res_ram_nxt    = 1'b1;
                ram_re         = 1'b1;
                count_nxt      = cnt_m1;
                if (in_kind == deq_pkg::KIND_POP_F) begin
                  ram_raddr = front_r;
                  front_nxt = (cnt_m1 == '0) ? '0 : front_inc;
                end else begin
                  ram_raddr = ring_idx(front_r, cnt_m1[AW-1:0]);
                  front_nxt = (cnt_m1 == '0) ? '0 : front_r;
                end
              end
            end
            deq_pkg::KIND_DUMP: begin
              if (count_r == '0) begin
                state_nxt      = S_RESP;
                res_status_nxt = deq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_DOUT;
                ram_re    = 1'b1;
                ram_raddr = front_r;
                idx_nxt   = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_ram_r ? ram_rdata : '0;
          out_pos_nxt    = '0;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_DOUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = deq_pkg::ST_OK;
          out_value_nxt  = ram_rdata;
          out_pos_nxt    = deq_pkg::POS_W'(dump_pos);
          out_last_nxt   = dump_last;
          if (dump_last) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = ring_idx(front_r, idx_r + AW'(1));
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    res_status_r <= res_status_nxt;
    res_ram_r    <= res_ram_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_pos_r    <= out_pos_nxt;
    out_last_r   <= out_last_nxt;
  end

  deq_ram #(
    .WIDTH (deq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(deq_pkg::OUT_TDATA_W - deq_pkg::WORD_W - deq_pkg::POS_W)'(0),
                       out_pos_r, out_value_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  `DEQ_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_FULL)
  `DEQ_ASSERT_NOW(a_front_bound, clk, rst_n, 1'b1, front_r <= LAST_IDX)
  `DEQ_ASSERT_NOW(a_empty_front, clk, rst_n, count_r == '0, front_r == '0)
  `DEQ_ASSERT_NOW(a_dump_idx, clk, rst_n, state_r == S_DOUT, CW'(idx_r) < count_r)
  `DEQ_ASSERT_NEXT(a_dump_hold, clk, rst_n, state_r == S_DOUT && !out_free,
                   $stable(idx_r) && $stable(count_r) && $stable(front_r))

endmodule

// ===== dv/testbench.sv =====
// self-checking bench for the double-ended queue: mirrored deque, random command streams
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH_WORDS = 64;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AFTER_ITEMS = 30;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS = 10;
  localparam deq_pkg::kind_t KIND_SPARE_LO = 3'd6;
  localparam deq_pkg::kind_t KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    deq_pkg::status_t status;
    logic [31:0]      word;
    logic [6:0]       pos;
    logic             last;
  } deq_reply_t;

  class deque_mirror;
    logic [31:0] words [DEPTH_WORDS];
    int unsigned head;
    int unsigned fill;
    deq_reply_t awaited_replies[$];
    int errors;

    function new();
      head = 0;
      fill = 0;
      errors = 0;
    endfunction

    function void expect_reply(deq_pkg::status_t st, logic [31:0] w, logic [6:0] p, logic l);
      deq_reply_t r;
      r.status = st;
      r.word = w;
      r.pos = p;
      r.last = l;
      awaited_replies.push_back(r);
    endfunction

    function deq_pkg::status_t append_back(logic [31:0] w);
      if (fill >= DEPTH_WORDS) return deq_pkg::ST_FULL;
      words[(head + fill) % DEPTH_WORDS] = w;
      fill++;
      return deq_pkg::ST_OK;
    endfunction

    function deq_pkg::status_t append_front(logic [31:0] w);
      if (fill >= DEPTH_WORDS) return deq_pkg::ST_FULL;
      head = (head + DEPTH_WORDS - 1) % DEPTH_WORDS;
      words[head] = w;
      fill++;
      return deq_pkg::ST_OK;
    endfunction

    function void apply_command(deq_pkg::kind_t k, logic [31:0] w, logic fresh);
      logic [31:0] got;
      case (k)
        deq_pkg::KIND_BUILD: begin
          if (fresh) begin
            head = 0;
            fill = 0;
          end
          expect_reply(append_back(w), '0, '0, 1'b1);
        end
        deq_pkg::KIND_PUSH_F, deq_pkg::KIND_PUSH_B: begin
          if (fill == 0) expect_reply(deq_pkg::ST_EMPTY, '0, '0, 1'b1);
          else if (k == deq_pkg::KIND_PUSH_F) expect_reply(append_front(w), '0, '0, 1'b1);
          else expect_reply(append_back(w), '0, '0, 1'b1);
        end
        deq_pkg::KIND_POP_F, deq_pkg::KIND_POP_B: begin
          if (fill == 0) begin
            expect_reply(deq_pkg::ST_EMPTY, '0, '0, 1'b1);
          end else begin
            if (k == deq_pkg::KIND_POP_F) begin
              got = words[head];
              head = (head + 1) % DEPTH_WORDS;
            end else begin
              got = words[(head + fill - 1) % DEPTH_WORDS];
            end
            fill--;
            if (fill == 0) head = 0;
            expect_reply(deq_pkg::ST_OK, got, '0, 1'b1);
          end
        end
        deq_pkg::KIND_DUMP: begin
          if (fill == 0) expect_reply(deq_pkg::ST_EMPTY, '0, '0, 1'b1);
          else
            for (int i = 0; i < fill; i++)
              expect_reply(deq_pkg::ST_OK, words[(head + i) % DEPTH_WORDS], 7'(i + 1),
                           (i + 1 == fill));
        end
        default: ;
      endcase
    endfunction

    function void compare_result(deq_reply_t got);
      deq_reply_t want;
      if (awaited_replies.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected item: status %0d value %h pos %0d last %0d",
                   got.status, got.word, got.pos, got.last);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.status !== want.status || got.word !== want.word ||
          got.pos !== want.pos || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected status %0d value %h pos %0d last %0d, %s %0d %h %0d %0d",
                   want.status, want.word, want.pos, want.last, "got",
                   got.status, got.word, got.pos, got.last);
      end
    endfunction

    function int waiting();
      return awaited_replies.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [deq_pkg::IN_TDATA_W-1:0] in_tdata;
  logic [deq_pkg::KIND_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [deq_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [deq_pkg::STATUS_W-1:0] out_tuser;
  logic out_tlast;

  deque_mirror mirror;
  int items_in = 0;
  int counted_items = 0;
  bit fast_sender = 1'b0;
  bit hold_done = 1'b0;
  int idle_cycles = 0;

  double_ended_queue #(.DEPTH(DEPTH_WORDS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(deq_pkg::kind_t k, logic [31:0] w, logic fresh);
    int gap;
    gap = fast_sender ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {7'b0, fresh, w};
    in_tuser <= k;
    do @(posedge clk); while (!in_tready);
    mirror.apply_command(k, w, fresh);
    items_in++;
    if (k <= deq_pkg::KIND_DUMP) counted_items++;
  endtask

  task automatic fill_to_overflow();
    send_item(deq_pkg::KIND_BUILD, rand_word(), 1'b1);
    for (int i = 0; i < DEPTH_WORDS + 3; i++)
      send_item($urandom_range(0, 1) ? deq_pkg::KIND_PUSH_F : deq_pkg::KIND_PUSH_B,
                rand_word(), 1'($urandom_range(0, 1)));
    send_item(deq_pkg::KIND_BUILD, rand_word(), 1'b0);
    send_item(deq_pkg::KIND_DUMP, rand_word(), 1'b0);
    send_item(deq_pkg::KIND_BUILD, rand_word(), 1'b1);
  endtask

  task automatic run_episode();
    int n;
    int mode;
    int pick;
    deq_pkg::kind_t k;
    mode = $urandom_range(0, 2);
    fast_sender = ($urandom_range(0, 3) == 0);
    n = (mode == 0) ? $urandom_range(20, 80) : $urandom_range(10, 50);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      case (mode)
        0: k = pick < 40 ? deq_pkg::KIND_BUILD : pick < 65 ? deq_pkg::KIND_PUSH_F :
               pick < 90 ? deq_pkg::KIND_PUSH_B : pick < 95 ? deq_pkg::KIND_DUMP :
               deq_pkg::KIND_POP_B;
        1: k = pick < 40 ? deq_pkg::KIND_POP_F : pick < 80 ? deq_pkg::KIND_POP_B :
               pick < 90 ? deq_pkg::KIND_DUMP : deq_pkg::KIND_BUILD;
        default: k = deq_pkg::kind_t'($urandom_range(0, 7));
      endcase
      send_item(k, rand_word(), ($urandom_range(0, 19) == 0));
    end
  endtask

  initial begin
    mirror = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = deq_pkg::KIND_BUILD;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty sequence, unused kinds, both extremes of the word
    send_item(deq_pkg::KIND_POP_F, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_POP_B, 32'h0, 1'b1);
    send_item(deq_pkg::KIND_DUMP, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_PUSH_F, 32'h7fff_ffff, 1'b0);
    send_item(deq_pkg::KIND_PUSH_B, 32'h8000_0000, 1'b0);
    send_item(KIND_SPARE_LO, 32'h1234_5678, 1'b0);
    send_item(KIND_SPARE_HI, 32'hffff_ffff, 1'b1);
    send_item(deq_pkg::KIND_BUILD, 32'h8000_0000, 1'b1);
    send_item(deq_pkg::KIND_BUILD, 32'h7fff_ffff, 1'b0);
    send_item(deq_pkg::KIND_PUSH_F, 32'hffff_ffff, 1'b1);
    send_item(deq_pkg::KIND_PUSH_B, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_DUMP, 32'h0, 1'b1);
    send_item(deq_pkg::KIND_POP_F, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_POP_B, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_DUMP, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_POP_F, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_POP_B, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_DUMP, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_BUILD, 32'h0000_0001, 1'b1);
    send_item(deq_pkg::KIND_POP_B, 32'h0, 1'b0);
    send_item(deq_pkg::KIND_PUSH_B, 32'h5555_aaaa, 1'b0);
    send_item(deq_pkg::KIND_BUILD, 32'haaaa_5555, 1'b0);
    send_item(deq_pkg::KIND_POP_F, 32'h0, 1'b0);

    counted_items = 0;
    fast_sender = 1'b1;
    fill_to_overflow();
    while (counted_items < RANDOM_ITEMS) run_episode();
    fill_to_overflow();
    in_tvalid <= 1'b0;

    while (mirror.waiting() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.waiting() == 0) begin
      $display("PASS double_ended_queue");
    end else begin
      $display("FAIL double_ended_queue");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off to back the block up
  initial begin
    int run;
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && items_in >= HOLD_AFTER_ITEMS) begin
        hold_done = 1'b1;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
        out_tready <= 1'b1;
        repeat (run) @(posedge clk);
        stall = idle_len();
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      mirror.compare_result({out_tuser, out_tdata[31:0], out_tdata[38:32], out_tlast});
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL double_ended_queue");
        $finish;
      end
    end
  end

endmodule
